// ===== sv/gf67_pkg.sv =====
`default_nettype none
package gf67_pkg;

    localparam int unsigned ElemW  = 67;
    localparam int unsigned DigitW = 34;
    localparam int unsigned ProdW  = 2 * ElemW - 1;   // 133
    localparam int unsigned PartW  = ElemW + DigitW - 1; // 100
    localparam int unsigned CntW   = 6;
    localparam int unsigned StepW  = 4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_SQR = 2'd2,
        OP_INV = 2'd3
    } t_op;

    // multiplier right-hand operand select
    typedef enum logic [1:0] {
        MSEL_A  = 2'd0,
        MSEL_B  = 2'd1,
        MSEL_Y  = 2'd2,
        MSEL_A7 = 2'd3
    } t_msel;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_SQR  = 3'd1,
        ST_MHI  = 3'd2,
        ST_MLO  = 3'd3,
        ST_DONE = 3'd4
    } t_state;

    typedef struct packed {
        logic  load;
        logic  load_add;
        logic  sqr;
        logic  mul_hi;
        logic  mul_lo;
        logic  save_y;
        logic  save_a7;
        t_msel msel;
    } t_dp_cmd;

    typedef struct packed {
        logic [CntW-1:0] nsq;
        logic            save_y;
        logic            save_a7;
        logic            has_mul;
        t_msel           msel;
    } t_inv_step;

    localparam logic [StepW-1:0] InvLastStep = 4'd8;

    // Itoh-Tsujii chain for a^(2^67-2): a run of squarings, then an optional multiply
    function automatic t_inv_step inv_step(input logic [StepW-1:0] idx);
        t_inv_step s;
        s = '{nsq: 6'd1, save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b0, msel: MSEL_A};
        case (idx)
            4'd0: s = '{nsq: 6'd1,  save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_A};
            4'd1: s = '{nsq: 6'd1,  save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_A};
            4'd2: s = '{nsq: 6'd3,  save_y: 1'b1, save_a7: 1'b1, has_mul: 1'b1, msel: MSEL_Y};
            4'd3: s = '{nsq: 6'd6,  save_y: 1'b1, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_Y};
            4'd4: s = '{nsq: 6'd3,  save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_A7};
            4'd5: s = '{nsq: 6'd15, save_y: 1'b1, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_Y};
            4'd6: s = '{nsq: 6'd3,  save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_A7};
            4'd7: s = '{nsq: 6'd33, save_y: 1'b1, save_a7: 1'b0, has_mul: 1'b1, msel: MSEL_Y};
            4'd8: s = '{nsq: 6'd1,  save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b0, msel: MSEL_A};
            default: s = '{nsq: 6'd1, save_y: 1'b0, save_a7: 1'b0, has_mul: 1'b0, msel: MSEL_A};
        endcase
        return s;
    endfunction

    // carry-less product of an element with one 34-bit digit
    function automatic logic [PartW-1:0] clmul_digit(input logic [ElemW-1:0] x,
                                                      input logic [DigitW-1:0] d);
        logic [PartW-1:0] p;
        p = '0;
        for (int i = 0; i < DigitW; i++) begin
            if (d[i]) begin
                p = p ^ ({33'b0, x} << i);
            end
        end
        return p;
    endfunction

    // reduce modulo x^67 + x^5 + x^2 + x + 1, two folds
    function automatic logic [ElemW-1:0] reduce(input logic [ProdW-1:0] v);
        logic [65:0] h1;
        logic [71:0] t;
        logic [4:0]  h2;
        h1 = v[132:67];
        t  = {5'b0, v[66:0]} ^ {6'b0, h1} ^ {5'b0, h1, 1'b0} ^ {4'b0, h1, 2'b0}
           ^ {1'b0, h1, 5'b0};
        h2 = t[71:67];
        return t[66:0] ^ {62'b0, h2} ^ {61'b0, h2, 1'b0} ^ {60'b0, h2, 2'b0}
             ^ {57'b0, h2, 5'b0};
    endfunction

    function automatic logic [ProdW-1:0] spread(input logic [ElemW-1:0] x);
        logic [ProdW-1:0] s;
        s = '0;
        for (int i = 0; i < ElemW; i++) begin
            s[2*i] = x[i];
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== sv/gf67_dp.sv =====
`default_nettype none
module gf67_dp (
    input  wire                        i_clk,
    input  wire gf67_pkg::t_dp_cmd     i_cmd,
    input  wire [gf67_pkg::ElemW-1:0]  i_a,
    input  wire [gf67_pkg::ElemW-1:0]  i_b,
    output logic [gf67_pkg::ElemW-1:0] o_result
);

    logic [gf67_pkg::ElemW-1:0] r_x;
    logic [gf67_pkg::ElemW-1:0] r_a;
    logic [gf67_pkg::ElemW-1:0] r_b;
    logic [gf67_pkg::ElemW-1:0] r_y;
    logic [gf67_pkg::ElemW-1:0] r_a7;
    logic [gf67_pkg::ElemW-1:0] r_p;

    logic [gf67_pkg::ElemW-1:0] w_m;
    logic [gf67_pkg::ElemW-1:0] w_sq;
    logic [gf67_pkg::ElemW-1:0] w_hi;
    logic [gf67_pkg::ElemW-1:0] w_lo;

    always_comb begin
        case (i_cmd.msel)
            gf67_pkg::MSEL_A:  w_m = r_a;
            gf67_pkg::MSEL_B:  w_m = r_b;
            gf67_pkg::MSEL_Y:  w_m = r_y;
            gf67_pkg::MSEL_A7: w_m = r_a7;
            default:           w_m = r_a;
        endcase
    end

    assign w_sq = gf67_pkg::reduce(gf67_pkg::spread(r_x));

    // high digit first: x * m[66:34], reduced
    assign w_hi = gf67_pkg::reduce({33'b0, gf67_pkg::clmul_digit(r_x, {1'b0, w_m[66:34]})});

    // then partial * x^34 plus x * m[33:0]
    assign w_lo = gf67_pkg::reduce({32'b0, r_p, 34'b0}
                                   ^ {33'b0, gf67_pkg::clmul_digit(r_x, w_m[33:0])});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_a;
            r_b <= i_b;
            r_x <= i_cmd.load_add ? (i_a ^ i_b) : i_a;
        end else if (i_cmd.sqr) begin
            r_x <= w_sq;
        end else if (i_cmd.mul_lo) begin
            r_x <= w_lo;
        end
        if (i_cmd.mul_hi) begin
            r_p <= w_hi;
        end
        // save the value before the first squaring of a run
        if (i_cmd.save_y) begin
            r_y <= r_x;
        end
        if (i_cmd.save_a7) begin
            r_a7 <= r_x;
        end
    end

    assign o_result = r_x;

endmodule
`default_nettype wire

// ===== sv/gf67_ctrl.sv =====
`default_nettype none
module gf67_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire [1:0]               i_op,
    input  wire                     i_out_ready,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output gf67_pkg::t_dp_cmd       o_cmd
);

    gf67_pkg::t_state                 r_state, n_state;
    gf67_pkg::t_op                    r_op, n_op;
    logic [gf67_pkg::StepW-1:0]       r_step, n_step;
    logic [gf67_pkg::CntW-1:0]        r_cnt, n_cnt;
    logic                             r_first, n_first;

    gf67_pkg::t_inv_step              w_cur;
    gf67_pkg::t_inv_step              w_nxt;
    logic [gf67_pkg::StepW-1:0]       w_step_inc;
    logic                             w_inv;

    assign w_step_inc = r_step + 4'd1;
    assign w_cur      = gf67_pkg::inv_step(r_step);
    assign w_nxt      = gf67_pkg::inv_step(w_step_inc);
    assign w_inv      = (r_op == gf67_pkg::OP_INV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gf67_pkg::ST_IDLE;
            r_op    <= gf67_pkg::OP_ADD;
            r_step  <= '0;
            r_cnt   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_first = r_first;
        case (r_state)
            gf67_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = gf67_pkg::t_op'(i_op);
                    n_step  = '0;
                    n_first = 1'b1;
                    n_cnt   = gf67_pkg::inv_step('0).nsq; // square and invert both start with one
                    case (gf67_pkg::t_op'(i_op))
                        gf67_pkg::OP_ADD: n_state = gf67_pkg::ST_DONE;
                        gf67_pkg::OP_MUL: n_state = gf67_pkg::ST_MHI;
                        default:          n_state = gf67_pkg::ST_SQR;
                    endcase
                end
            end
            gf67_pkg::ST_SQR: begin
                n_first = 1'b0;
                if (r_cnt == 6'd1) begin
                    if (w_inv && w_cur.has_mul) begin
                        n_state = gf67_pkg::ST_MHI;
                    end else begin
                        n_state = gf67_pkg::ST_DONE;
                    end
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            gf67_pkg::ST_MHI: begin
                n_state = gf67_pkg::ST_MLO;
            end
            gf67_pkg::ST_MLO: begin
                if (w_inv && r_step != gf67_pkg::InvLastStep) begin
                    n_step  = w_step_inc;
                    n_cnt   = w_nxt.nsq;
                    n_first = 1'b1;
                    n_state = gf67_pkg::ST_SQR;
                end else begin
                    n_state = gf67_pkg::ST_DONE;
                end
            end
            gf67_pkg::ST_DONE: begin
                if (i_out_ready) begin
                    n_state = gf67_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gf67_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.msel     = w_inv ? w_cur.msel : gf67_pkg::MSEL_B;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            gf67_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load     = i_in_valid;
                o_cmd.load_add = (gf67_pkg::t_op'(i_op) == gf67_pkg::OP_ADD);
            end
            gf67_pkg::ST_SQR: begin
                o_cmd.sqr     = 1'b1;
                o_cmd.save_y  = w_inv & r_first & w_cur.save_y;
                o_cmd.save_a7 = w_inv & r_first & w_cur.save_a7;
            end
            gf67_pkg::ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
            end
            gf67_pkg::ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
            end
            gf67_pkg::ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/gf2_67_field_arithmetic_unit.sv =====
// GF(2^67) unit, one word in flight at a time; input ready only when idle.
// Add completes on load; square runs one squaring; multiply runs a high-digit then a low-digit step;
// invert runs 66 squarings plus 8 digit multiplies, each a high-digit then a low-digit step.
// A new word is accepted only after the previous result is taken on the output handshake.
// Synchronous active-low reset clears the controller; datapath registers are not reset.
`default_nettype none
module gf2_67_field_arithmetic_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [63:0] operand_a_low, [66:64] operand_a_high, [130:67] operand_b_low,
    // [133:131] operand_b_high, [135:134] zero
    input  wire [135:0]  i_s_axis_tdata,
    // [1:0] operation
    input  wire [1:0]    i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // [63:0] result_low, [66:64] result_high, [71:67] zero
    output logic [71:0]  o_m_axis_tdata
);

    gf67_pkg::t_dp_cmd             w_cmd;
    logic [gf67_pkg::ElemW-1:0]    w_result;

    gf67_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_op        (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    gf67_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_a      (i_s_axis_tdata[66:0]),
        .i_b      (i_s_axis_tdata[133:67]),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = {5'b0, w_result};

endmodule
`default_nettype wire
